>>> rtl/core/rips_pkg.sv
`timescale 1ns / 1ps

package rips_pkg;

    // sizes
    localparam int NUM_PROCS  = 16;
    localparam int NUM_LEVELS = 3;
    localparam int NUM_IRQS   = 32;

    localparam int PID_W  = $clog2(NUM_PROCS);
    localparam int LINK_W = PID_W + 1;
    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PRIO_W = $clog2(NUM_LEVELS + 1);
    localparam int IRQ_W  = (NUM_IRQS > 1) ? $clog2(NUM_IRQS) : 1;
    localparam int CNT_W  = $clog2(NUM_PROCS + 1);

    // fixed field widths
    localparam int REQ_W  = 4;
    localparam int ARG_W  = 5;
    localparam int ADDR_W = 32;
    localparam int ACT_W  = 2;
    localparam int SND_W  = 5;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 2;
    localparam int XW     = ((PID_W > ARG_W) ? PID_W : ARG_W) + 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_YIELD   = 4'd0;
    localparam logic [REQ_W-1:0] REQ_SEND    = 4'd1;
    localparam logic [REQ_W-1:0] REQ_RECEIVE = 4'd2;
    localparam logic [REQ_W-1:0] REQ_SENDREC = 4'd3;
    localparam logic [REQ_W-1:0] REQ_EXIT    = 4'd4;
    localparam logic [REQ_W-1:0] REQ_CONNECT = 4'd5;
    localparam logic [REQ_W-1:0] REQ_SETPRIO = 4'd6;
    localparam logic [REQ_W-1:0] REQ_START   = 4'd7;
    localparam logic [REQ_W-1:0] REQ_IRQ     = 4'd8;

    // accept values
    localparam logic [ARG_W-1:0] ACC_ANY = 5'd16;
    localparam logic [ARG_W-1:0] ACC_HW  = 5'd17;
    localparam logic [SND_W-1:0] SND_HW  = 5'd16;

    // process states
    localparam logic [2:0] PS_DEAD      = 3'd0;
    localparam logic [2:0] PS_READY     = 3'd1;
    localparam logic [2:0] PS_SENDING   = 3'd2;
    localparam logic [2:0] PS_RECEIVING = 3'd3;
    localparam logic [2:0] PS_BOTH      = 3'd4;
    localparam logic [2:0] PS_IDLING    = 3'd5;

    // message actions
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COPY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_IRQ  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPRIO = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOIRQ   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPID  = 2'd3;

    localparam logic [LINK_W-1:0] LINK_NIL = {1'b1, {PID_W{1'b0}}};

    // one process table entry
    typedef struct packed {
        logic [2:0]        status;
        logic [PRIO_W-1:0] prio;
        logic [ARG_W-1:0]  accept;
        logic [ADDR_W-1:0] buffer;
        logic              pending;
        logic [LINK_W-1:0] link;
        logic [LINK_W-1:0] whead;
    } t_proc;

    // table port request
    typedef struct packed {
        logic             rd_en;
        logic [PID_W-1:0] rd_addr;
        logic             wr_en;
        logic [PID_W-1:0] wr_addr;
        t_proc            wr_data;
    } t_mreq;

    function automatic t_proc proc_reset(input logic [PID_W-1:0] p);
        t_proc e;
        e.status  = (p == '0) ? PS_IDLING : PS_DEAD;
        e.prio    = (p == '0) ? PRIO_W'(NUM_LEVELS) : PRIO_W'(2);
        e.accept  = ACC_ANY;
        e.buffer  = '0;
        e.pending = 1'b0;
        e.link    = LINK_NIL;
        e.whead   = LINK_NIL;
        return e;
    endfunction

    function automatic logic arg_is_pid(input logic [ARG_W-1:0] a);
        return XW'(a) < XW'(NUM_PROCS);
    endfunction

    function automatic logic link_is_pid(input logic [LINK_W-1:0] l);
        return !l[PID_W];
    endfunction

    function automatic logic [LVL_W-1:0] prio_level(input logic [PRIO_W-1:0] p);
        return (XW'(p) > XW'(NUM_LEVELS - 1)) ? LVL_W'(NUM_LEVELS - 1) : LVL_W'(p);
    endfunction

endpackage

>>> rtl/core/rips_ptab.sv
`timescale 1ns / 1ps

module rips_ptab (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rips_pkg::t_mreq         i_req,
    output rips_pkg::t_proc         o_rd_data
);

    rips_pkg::t_proc                    r_mem [rips_pkg::NUM_PROCS];
    logic [rips_pkg::NUM_PROCS-1:0]     r_vld;
    rips_pkg::t_proc                    r_rdata;
    logic                               r_rvld;
    logic [rips_pkg::PID_W-1:0]         r_raddr;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
            r_raddr <= i_req.rd_addr;
        end
    end

    // track written entries; others read as their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rvld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : rips_pkg::proc_reset(r_raddr);

endmodule

>>> rtl/core/rips_seq.sv
`timescale 1ns / 1ps

module rips_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rips_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rips_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rips_pkg::ARG_W-1:0]    i_arg,
    input  logic [rips_pkg::ADDR_W-1:0]   i_msg_addr,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rips_pkg::PID_W-1:0]    o_next_pid,
    output logic [rips_pkg::ACT_W-1:0]    o_msg_action,
    output logic [rips_pkg::ADDR_W-1:0]   o_msg_src_addr,
    output logic [rips_pkg::ADDR_W-1:0]   o_msg_dst_addr,
    output logic [rips_pkg::SND_W-1:0]    o_msg_sender,
    output logic                          o_irq_disable,
    output logic [rips_pkg::STAT_W-1:0]   o_status,
    output rips_pkg::t_mreq               o_mreq,
    input  rips_pkg::t_proc               i_pv
);

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_DISP = 6'd1;
    localparam logic [5:0] S_MR0  = 6'd2;
    localparam logic [5:0] S_MR1  = 6'd3;
    localparam logic [5:0] S_MR2  = 6'd4;
    localparam logic [5:0] S_MR3  = 6'd5;
    localparam logic [5:0] S_CN0  = 6'd6;
    localparam logic [5:0] S_CN1  = 6'd7;
    localparam logic [5:0] S_SR1  = 6'd8;
    localparam logic [5:0] S_SR2  = 6'd9;
    localparam logic [5:0] S_SR3  = 6'd10;
    localparam logic [5:0] S_SR4  = 6'd11;
    localparam logic [5:0] S_NM1  = 6'd12;
    localparam logic [5:0] S_JW0  = 6'd13;
    localparam logic [5:0] S_JW1  = 6'd14;
    localparam logic [5:0] S_JW2  = 6'd15;
    localparam logic [5:0] S_JW3  = 6'd16;
    localparam logic [5:0] S_RV1  = 6'd17;
    localparam logic [5:0] S_RW0  = 6'd18;
    localparam logic [5:0] S_RW1  = 6'd19;
    localparam logic [5:0] S_RM0  = 6'd20;
    localparam logic [5:0] S_RM1  = 6'd21;
    localparam logic [5:0] S_RM2  = 6'd22;
    localparam logic [5:0] S_RM3  = 6'd23;
    localparam logic [5:0] S_RVW0 = 6'd24;
    localparam logic [5:0] S_RVW1 = 6'd25;
    localparam logic [5:0] S_EX1  = 6'd26;
    localparam logic [5:0] S_CO1  = 6'd27;
    localparam logic [5:0] S_SP1  = 6'd28;
    localparam logic [5:0] S_ST1  = 6'd29;
    localparam logic [5:0] S_IN1  = 6'd30;
    localparam logic [5:0] S_IN2  = 6'd31;
    localparam logic [5:0] S_IN3  = 6'd32;
    localparam logic [5:0] S_IN4  = 6'd33;
    localparam logic [5:0] S_DONE = 6'd34;

    localparam int PW = rips_pkg::PID_W;
    localparam int LW = rips_pkg::LINK_W;
    localparam int NL = rips_pkg::NUM_LEVELS;

    logic [5:0]                     r_state, n_state, r_ret, n_ret;
    logic [rips_pkg::REQ_W-1:0]     r_req, n_req;
    logic [rips_pkg::ARG_W-1:0]     r_arg, n_arg;
    logic [rips_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [PW-1:0]                  r_cur, n_cur;
    logic [rips_pkg::ACT_W-1:0]     r_act, n_act;
    logic [rips_pkg::ADDR_W-1:0]    r_src, n_src, r_dst, n_dst;
    logic [rips_pkg::SND_W-1:0]     r_snd, n_snd;
    logic                           r_dis, n_dis;
    logic [rips_pkg::STAT_W-1:0]    r_stat, n_stat;
    logic [PW-1:0]                  r_mp, n_mp, r_hp, n_hp, r_tl, n_tl;
    logic [rips_pkg::LVL_W-1:0]     r_lvl, n_lvl;
    logic [LW-1:0]                  r_walk, n_walk, r_prev, n_prev, r_lps, n_lps;
    logic [rips_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_flag, n_flag;
    logic [rips_pkg::CFG_W-1:0]     r_sprio;
    logic [LW-1:0]                  r_rhead [NL];
    logic [LW-1:0]                  n_rhead [NL];
    logic [LW-1:0]                  r_rtail [NL];
    logic [LW-1:0]                  n_rtail [NL];
    logic [PW-1:0]                  r_owner [rips_pkg::NUM_IRQS];
    logic                           owner_we;
    logic [rips_pkg::IRQ_W-1:0]     irq_idx;
    logic                           irq_bad;
    logic                           cn_found;
    logic [rips_pkg::LVL_W-1:0]     cn_lvl;
    logic                           out_load;

    logic                           r_ovalid;
    logic [PW-1:0]                  r_o_pid;
    logic [rips_pkg::ACT_W-1:0]     r_o_act;
    logic [rips_pkg::ADDR_W-1:0]    r_o_src, r_o_dst;
    logic [rips_pkg::SND_W-1:0]     r_o_snd;
    logic                           r_o_dis;
    logic [rips_pkg::STAT_W-1:0]    r_o_stat;

    assign irq_idx = rips_pkg::IRQ_W'(r_arg);
    assign irq_bad = rips_pkg::XW'(r_arg) >= rips_pkg::XW'(rips_pkg::NUM_IRQS);
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    // pick the first non-empty ready level
    always_comb begin
        cn_found = 1'b0;
        cn_lvl   = '0;
        for (int l = NL - 1; l >= 0; l--) begin
            if (rips_pkg::link_is_pid(r_rhead[l])) begin
                cn_found = 1'b1;
                cn_lvl   = rips_pkg::LVL_W'(l);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_req   = r_req;
        n_arg   = r_arg;
        n_addr  = r_addr;
        n_cur   = r_cur;
        n_act   = r_act;
        n_src   = r_src;
        n_dst   = r_dst;
        n_snd   = r_snd;
        n_dis   = r_dis;
        n_stat  = r_stat;
        n_mp    = r_mp;
        n_hp    = r_hp;
        n_tl    = r_tl;
        n_lvl   = r_lvl;
        n_walk  = r_walk;
        n_prev  = r_prev;
        n_lps   = r_lps;
        n_cnt   = r_cnt;
        n_flag  = r_flag;
        n_rhead = r_rhead;
        n_rtail = r_rtail;
        owner_we = 1'b0;
        o_mreq.rd_en   = 1'b0;
        o_mreq.rd_addr = r_cur;
        o_mreq.wr_en   = 1'b0;
        o_mreq.wr_addr = r_cur;
        o_mreq.wr_data = i_pv;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_arg   = i_arg;
                    n_addr  = i_msg_addr;
                    n_act   = rips_pkg::ACT_NONE;
                    n_src   = '0;
                    n_dst   = '0;
                    n_snd   = '0;
                    n_dis   = 1'b0;
                    n_stat  = rips_pkg::ST_OK;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_req)
                    rips_pkg::REQ_YIELD: begin
                        n_mp    = r_cur;
                        n_ret   = S_CN0;
                        n_state = S_MR0;
                    end
                    rips_pkg::REQ_SEND, rips_pkg::REQ_SENDREC: begin
                        if (!rips_pkg::arg_is_pid(r_arg)) begin
                            n_stat  = rips_pkg::ST_BADPID;
                            n_state = S_DONE;
                        end else begin
                            o_mreq.rd_en = 1'b1;
                            n_state      = S_SR1;
                        end
                    end
                    rips_pkg::REQ_RECEIVE: begin
                        o_mreq.rd_en = 1'b1;
                        n_state      = S_RV1;
                    end
                    rips_pkg::REQ_EXIT: begin
                        o_mreq.rd_en = 1'b1;
                        n_state      = S_EX1;
                    end
                    rips_pkg::REQ_CONNECT: begin
                        if (irq_bad) begin
                            n_stat  = rips_pkg::ST_NOIRQ;
                            n_state = S_DONE;
                        end else begin
                            o_mreq.rd_en = 1'b1;
                            n_state      = S_CO1;
                        end
                    end
                    rips_pkg::REQ_SETPRIO: begin
                        if (rips_pkg::XW'(r_arg) > rips_pkg::XW'(NL - 1)) begin
                            n_stat  = rips_pkg::ST_BADPRIO;
                            n_state = S_DONE;
                        end else begin
                            o_mreq.rd_en = 1'b1;
                            n_state      = S_SP1;
                        end
                    end
                    rips_pkg::REQ_START: begin
                        if (!rips_pkg::arg_is_pid(r_arg) || r_arg == '0) begin
                            n_stat  = rips_pkg::ST_BADPID;
                            n_state = S_DONE;
                        end else begin
                            o_mreq.rd_en   = 1'b1;
                            o_mreq.rd_addr = PW'(r_arg);
                            n_state        = S_ST1;
                        end
                    end
                    rips_pkg::REQ_IRQ: begin
                        if (irq_bad || r_owner[irq_idx] == '0) begin
                            n_stat  = rips_pkg::ST_NOIRQ;
                            n_state = S_DONE;
                        end else begin
                            n_dis          = 1'b1;
                            n_hp           = r_owner[irq_idx];
                            o_mreq.rd_en   = 1'b1;
                            o_mreq.rd_addr = r_owner[irq_idx];
                            n_state        = S_IN1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // make ready: mark the entry, then append to its level
            S_MR0: begin
                if (r_mp == '0) begin
                    n_state = r_ret;
                end else begin
                    o_mreq.rd_en   = 1'b1;
                    o_mreq.rd_addr = r_mp;
                    n_state        = S_MR1;
                end
            end
            S_MR1: begin
                o_mreq.wr_en          = 1'b1;
                o_mreq.wr_addr        = r_mp;
                o_mreq.wr_data.status = rips_pkg::PS_READY;
                o_mreq.wr_data.link   = rips_pkg::LINK_NIL;
                n_lvl = rips_pkg::prio_level(i_pv.prio);
                n_rtail[n_lvl] = {1'b0, r_mp};
                if (!rips_pkg::link_is_pid(r_rhead[n_lvl]) ||
                    !rips_pkg::link_is_pid(r_rtail[n_lvl])) begin
                    n_rhead[n_lvl] = {1'b0, r_mp};
                    n_state        = r_ret;
                end else begin
                    n_tl    = r_rtail[n_lvl][PW-1:0];
                    n_state = S_MR2;
                end
            end
            S_MR2: begin
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = r_tl;
                n_state        = S_MR3;
            end
            S_MR3: begin
                o_mreq.wr_en        = 1'b1;
                o_mreq.wr_addr      = r_tl;
                o_mreq.wr_data.link = {1'b0, r_mp};
                n_state             = r_ret;
            end

            // choose next: pop the head of the first ready level, else pick process 0
            S_CN0: begin
                if (cn_found) begin
                    n_cur          = r_rhead[cn_lvl][PW-1:0];
                    n_lvl          = cn_lvl;
                    o_mreq.rd_en   = 1'b1;
                    o_mreq.rd_addr = r_rhead[cn_lvl][PW-1:0];
                    n_state        = S_CN1;
                end else begin
                    n_cur   = '0;
                    n_state = S_DONE;
                end
            end
            S_CN1: begin
                n_rhead[r_lvl] = i_pv.link;
                n_state        = S_DONE;
            end

            // send and sendrec
            S_SR1: begin
                if (r_req == rips_pkg::REQ_SENDREC) begin
                    o_mreq.wr_en          = 1'b1;
                    o_mreq.wr_data.accept = r_arg;
                    o_mreq.wr_data.buffer = r_addr;
                end
                n_state = S_SR2;
            end
            S_SR2: begin
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = PW'(r_arg);
                n_state        = S_SR3;
            end
            S_SR3: begin
                o_mreq.rd_en = 1'b1;
                if (i_pv.status == rips_pkg::PS_RECEIVING &&
                    (i_pv.accept == rips_pkg::ACC_ANY ||
                     rips_pkg::XW'(i_pv.accept) == rips_pkg::XW'(r_cur))) begin
                    n_act = rips_pkg::ACT_COPY;
                    n_src = r_addr;
                    n_dst = i_pv.buffer;
                    n_snd = rips_pkg::SND_W'(r_cur);
                    n_mp  = PW'(r_arg);
                    if (r_req == rips_pkg::REQ_SENDREC) begin
                        n_state = S_SR4;
                    end else begin
                        o_mreq.rd_en = 1'b0;
                        n_ret        = S_DONE;
                        n_state      = S_MR0;
                    end
                end else begin
                    n_state = S_NM1;
                end
            end
            S_SR4: begin
                o_mreq.wr_en          = 1'b1;
                o_mreq.wr_data.status = rips_pkg::PS_RECEIVING;
                n_ret                 = S_CN0;
                n_state               = S_MR0;
            end
            S_NM1: begin
                o_mreq.wr_en          = 1'b1;
                o_mreq.wr_data.status = (r_req == rips_pkg::REQ_SENDREC) ?
                                        rips_pkg::PS_BOTH : rips_pkg::PS_SENDING;
                o_mreq.wr_data.buffer = r_addr;
                o_mreq.wr_data.link   = rips_pkg::LINK_NIL;
                n_state               = S_JW0;
            end

            // join the sender queue of the target
            S_JW0: begin
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = PW'(r_arg);
                n_state        = S_JW1;
            end
            S_JW1: begin
                if (!rips_pkg::link_is_pid(i_pv.whead)) begin
                    o_mreq.wr_en         = 1'b1;
                    o_mreq.wr_addr       = PW'(r_arg);
                    o_mreq.wr_data.whead = {1'b0, r_cur};
                    n_state              = S_CN0;
                end else begin
                    n_walk  = i_pv.whead;
                    n_cnt   = '0;
                    n_state = S_JW2;
                end
            end
            S_JW2: begin
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = r_walk[PW-1:0];
                n_state        = S_JW3;
            end
            S_JW3: begin
                if (r_cnt < rips_pkg::CNT_W'(rips_pkg::NUM_PROCS) &&
                    rips_pkg::link_is_pid(i_pv.link)) begin
                    n_walk  = i_pv.link;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_JW2;
                end else begin
                    o_mreq.wr_en        = 1'b1;
                    o_mreq.wr_addr      = r_walk[PW-1:0];
                    o_mreq.wr_data.link = {1'b0, r_cur};
                    n_state             = S_CN0;
                end
            end

            // receive
            S_RV1: begin
                if (i_pv.pending &&
                    (r_arg == rips_pkg::ACC_ANY || r_arg == rips_pkg::ACC_HW)) begin
                    o_mreq.wr_en           = 1'b1;
                    o_mreq.wr_data.pending = 1'b0;
                    n_act   = rips_pkg::ACT_IRQ;
                    n_dst   = r_addr;
                    n_snd   = rips_pkg::SND_HW;
                    n_state = S_DONE;
                end else if (r_arg != rips_pkg::ACC_HW) begin
                    n_walk  = i_pv.whead;
                    n_prev  = rips_pkg::LINK_NIL;
                    n_cnt   = '0;
                    n_state = S_RW0;
                end else begin
                    n_state = S_RVW0;
                end
            end
            S_RW0: begin
                if (r_cnt < rips_pkg::CNT_W'(rips_pkg::NUM_PROCS) &&
                    rips_pkg::link_is_pid(r_walk)) begin
                    o_mreq.rd_en   = 1'b1;
                    o_mreq.rd_addr = r_walk[PW-1:0];
                    n_state        = S_RW1;
                end else begin
                    n_state = S_RVW0;
                end
            end
            S_RW1: begin
                if (r_arg == rips_pkg::ACC_ANY ||
                    rips_pkg::XW'(r_arg) == rips_pkg::XW'(r_walk)) begin
                    n_lps   = i_pv.link;
                    n_act   = rips_pkg::ACT_COPY;
                    n_src   = i_pv.buffer;
                    n_dst   = r_addr;
                    n_snd   = rips_pkg::SND_W'(r_walk[PW-1:0]);
                    n_state = S_RM0;
                end else begin
                    n_prev  = r_walk;
                    n_walk  = i_pv.link;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_RW0;
                end
            end
            // unlink the matched sender
            S_RM0: begin
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = rips_pkg::link_is_pid(r_prev) ? r_prev[PW-1:0] : r_cur;
                n_state        = S_RM1;
            end
            S_RM1: begin
                o_mreq.wr_en = 1'b1;
                if (rips_pkg::link_is_pid(r_prev)) begin
                    o_mreq.wr_addr      = r_prev[PW-1:0];
                    o_mreq.wr_data.link = r_lps;
                end else begin
                    o_mreq.wr_data.whead = r_lps;
                end
                n_state = S_RM2;
            end
            S_RM2: begin
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = r_walk[PW-1:0];
                n_state        = S_RM3;
            end
            S_RM3: begin
                if (i_pv.status == rips_pkg::PS_BOTH) begin
                    o_mreq.wr_en          = 1'b1;
                    o_mreq.wr_addr        = r_walk[PW-1:0];
                    o_mreq.wr_data.status = rips_pkg::PS_RECEIVING;
                    n_state               = S_DONE;
                end else begin
                    n_mp    = r_walk[PW-1:0];
                    n_ret   = S_DONE;
                    n_state = S_MR0;
                end
            end
            // block the caller as a receiver
            S_RVW0: begin
                o_mreq.rd_en = 1'b1;
                n_state      = S_RVW1;
            end
            S_RVW1: begin
                o_mreq.wr_en          = 1'b1;
                o_mreq.wr_data.status = rips_pkg::PS_RECEIVING;
                o_mreq.wr_data.accept = r_arg;
                o_mreq.wr_data.buffer = r_addr;
                n_state               = S_CN0;
            end

            S_EX1: begin
                o_mreq.wr_en          = 1'b1;
                o_mreq.wr_data.status = rips_pkg::PS_DEAD;
                n_state               = S_CN0;
            end
            S_CO1: begin
                o_mreq.wr_en        = 1'b1;
                o_mreq.wr_data.prio = '0;
                owner_we            = 1'b1;
                n_state             = S_DONE;
            end
            S_SP1: begin
                o_mreq.wr_en        = 1'b1;
                o_mreq.wr_data.prio = rips_pkg::PRIO_W'(r_arg);
                n_state             = S_DONE;
            end

            // start a dead process
            S_ST1: begin
                if (i_pv.status != rips_pkg::PS_DEAD) begin
                    n_stat  = rips_pkg::ST_BADPID;
                    n_state = S_DONE;
                end else begin
                    o_mreq.wr_en           = 1'b1;
                    o_mreq.wr_addr         = PW'(r_arg);
                    o_mreq.wr_data.prio    = rips_pkg::PRIO_W'(rips_pkg::prio_level(
                                             rips_pkg::PRIO_W'(r_sprio)));
                    o_mreq.wr_data.whead   = rips_pkg::LINK_NIL;
                    o_mreq.wr_data.pending = 1'b0;
                    o_mreq.wr_data.accept  = rips_pkg::ACC_ANY;
                    o_mreq.wr_data.buffer  = '0;
                    n_mp    = PW'(r_arg);
                    n_ret   = S_DONE;
                    n_state = S_MR0;
                end
            end

            // interrupt: deliver or mark pending, then maybe preempt
            S_IN1: begin
                if (i_pv.status == rips_pkg::PS_RECEIVING &&
                    (i_pv.accept == rips_pkg::ACC_ANY || i_pv.accept == rips_pkg::ACC_HW)) begin
                    n_act   = rips_pkg::ACT_IRQ;
                    n_dst   = i_pv.buffer;
                    n_snd   = rips_pkg::SND_HW;
                    n_mp    = r_hp;
                    n_ret   = S_IN2;
                    n_state = S_MR0;
                end else begin
                    o_mreq.wr_en           = 1'b1;
                    o_mreq.wr_addr         = r_hp;
                    o_mreq.wr_data.pending = 1'b1;
                    n_state                = S_IN2;
                end
            end
            S_IN2: begin
                o_mreq.rd_en = 1'b1;
                n_state      = S_IN3;
            end
            S_IN3: begin
                n_flag         = (i_pv.prio != '0);
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = r_hp;
                n_state        = S_IN4;
            end
            S_IN4: begin
                if (r_flag && i_pv.status == rips_pkg::PS_READY) begin
                    n_mp    = r_cur;
                    n_ret   = S_CN0;
                    n_state = S_MR0;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_DONE;
            r_cur    <= '0;
            r_sprio  <= rips_pkg::CFG_W'(2);
            r_ovalid <= 1'b0;
            for (int l = 0; l < NL; l++) begin
                r_rhead[l] <= rips_pkg::LINK_NIL;
                r_rtail[l] <= rips_pkg::LINK_NIL;
            end
            for (int q = 0; q < rips_pkg::NUM_IRQS; q++) begin
                r_owner[q] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cur   <= n_cur;
            r_rhead <= n_rhead;
            r_rtail <= n_rtail;
            if (i_cfg_we) begin
                r_sprio <= i_cfg_data;
            end
            if (owner_we) begin
                r_owner[irq_idx] <= r_cur;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working and result words
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_arg  <= n_arg;
        r_addr <= n_addr;
        r_act  <= n_act;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_snd  <= n_snd;
        r_dis  <= n_dis;
        r_stat <= n_stat;
        r_mp   <= n_mp;
        r_hp   <= n_hp;
        r_tl   <= n_tl;
        r_lvl  <= n_lvl;
        r_walk <= n_walk;
        r_prev <= n_prev;
        r_lps  <= n_lps;
        r_cnt  <= n_cnt;
        r_flag <= n_flag;
        if (out_load) begin
            r_o_pid  <= r_cur;
            r_o_act  <= r_act;
            r_o_src  <= r_src;
            r_o_dst  <= r_dst;
            r_o_snd  <= r_snd;
            r_o_dis  <= r_dis;
            r_o_stat <= r_stat;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_next_pid     = r_o_pid;
    assign o_msg_action   = r_o_act;
    assign o_msg_src_addr = r_o_src;
    assign o_msg_dst_addr = r_o_dst;
    assign o_msg_sender   = r_o_snd;
    assign o_irq_disable  = r_o_dis;
    assign o_status       = r_o_stat;

    // the table is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mreq.rd_en && o_mreq.wr_en))
        else $error("table read and write in one cycle");

    // an error word carries no action and no strobe
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_stat != rips_pkg::ST_OK) |->
        (r_o_act == rips_pkg::ACT_NONE && !r_o_dis))
        else $error("error word with side effects");

    // an interrupt message comes from hardware with no source buffer
    a_irq_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_act == rips_pkg::ACT_IRQ) |->
        (r_o_src == '0 && r_o_snd == rips_pkg::SND_HW))
        else $error("malformed interrupt message");

endmodule

>>> rtl/core/rendezvous_ipc_scheduler.sv
`timescale 1ns / 1ps

// Message-passing process scheduler: one request word in, one result word out. The process
// table lives in a synchronous memory with a registered read, never read and written in the
// same cycle, so every field update is a read followed by a write-back. A send that joins a
// sender queue or a receive that searches one walks that queue entry by entry, never more
// entries than there are processes. The input is ready again as soon as the result is loaded,
// even while that result still waits for the receiver. start_priority may be written at any
// time the block is idle; no clearing pass is needed after reset.
module rendezvous_ipc_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rips_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rips_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rips_pkg::ARG_W-1:0]    i_arg,
    input  logic [rips_pkg::ADDR_W-1:0]   i_msg_addr,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rips_pkg::PID_W-1:0]    o_next_pid,
    output logic [rips_pkg::ACT_W-1:0]    o_msg_action,
    output logic [rips_pkg::ADDR_W-1:0]   o_msg_src_addr,
    output logic [rips_pkg::ADDR_W-1:0]   o_msg_dst_addr,
    output logic [rips_pkg::SND_W-1:0]    o_msg_sender,
    output logic                          o_irq_disable,
    output logic [rips_pkg::STAT_W-1:0]   o_status
);

    rips_pkg::t_mreq mreq;
    rips_pkg::t_proc pv;

    // process table
    rips_ptab u_ptab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mreq),
        .o_rd_data (pv)
    );

    // request sequencer
    rips_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_arg          (i_arg),
        .i_msg_addr     (i_msg_addr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_next_pid     (o_next_pid),
        .o_msg_action   (o_msg_action),
        .o_msg_src_addr (o_msg_src_addr),
        .o_msg_dst_addr (o_msg_dst_addr),
        .o_msg_sender   (o_msg_sender),
        .o_irq_disable  (o_irq_disable),
        .o_status       (o_status),
        .o_mreq         (mreq),
        .i_pv           (pv)
    );

endmodule
